### hdl/lmts_pkg.sv
// Shared types, register offsets and timing constants for the LCD mode timing block.
// No dependencies; imported by every module of the block.
package lmts_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SM_HBLANK   = 2'd0,
		SM_VBLANK   = 2'd1,
		SM_SEARCH   = 2'd2,
		SM_TRANSFER = 2'd3
	} scr_mode_t;

	localparam logic [7:0] REG_CTRL     = 8'h40;
	localparam logic [7:0] REG_STATUS   = 8'h41;
	localparam logic [7:0] REG_SCY      = 8'h42;
	localparam logic [7:0] REG_SCX      = 8'h43;
	localparam logic [7:0] REG_LY       = 8'h44;
	localparam logic [7:0] REG_LYC      = 8'h45;
	localparam logic [7:0] REG_BGP      = 8'h47;
	localparam logic [7:0] REG_OBJ_PAL0 = 8'h48;
	localparam logic [7:0] REG_OBJ_PAL1 = 8'h49;
	localparam logic [7:0] REG_WY       = 8'h4A;
	localparam logic [7:0] REG_WX       = 8'h4B;

	localparam logic [8:0] DOTS_HBLANK   = 9'd204;
	localparam logic [8:0] DOTS_VBLANK   = 9'd456;
	localparam logic [8:0] DOTS_SEARCH   = 9'd80;
	localparam logic [8:0] DOTS_TRANSFER = 9'd172;

	localparam logic [7:0] VBLANK_LINE = 8'd144;
	localparam logic [7:0] NUM_LINES   = 8'd154;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] addr;
		logic [7:0] data;
	} item_t;

	// Sequencer state seen by the register file read mux
	typedef struct packed {
		scr_mode_t  mode;
		logic       coincidence;
		logic [3:0] enables;
		logic [7:0] line;
		logic [7:0] compare;
	} seq_stat_t;

	// Per-item result from the sequencer, values after the step
	typedef struct packed {
		logic       vblank_pulse;
		logic       stat_irq;
		scr_mode_t  mode;
		logic [7:0] line;
	} step_res_t;

	function automatic logic [8:0] mode_dots(scr_mode_t m);
		logic [8:0] d;
		unique case (m)
			SM_HBLANK: d = DOTS_HBLANK;
			SM_VBLANK: d = DOTS_VBLANK;
			SM_SEARCH: d = DOTS_SEARCH;
			default:   d = DOTS_TRANSFER;
		endcase
		return d;
	endfunction

endpackage

### hdl/lcd_mode_timing_stat_irq.sv
// LCD mode timing block: input register, sequencer and register file, result register.
// Depends on lmts_pkg, lmts_seq and lmts_regs.
//
// Each input transfer is a tick, a register read or a register write (kind in s_tuser); kind 3 does nothing.
// One item per clock while results are taken: an item is held in the input register, where
// the sequencer and register file act on it in a single pass, and its result lands in
// the output register. The input side keeps accepting while a result waits, until both
// registers are full.
// Every item yields exactly one result: read data (zero unless a read of a known
// register), vblank and STAT interrupt pulses, and the screen mode and line after
// the item. After reset the block is in transfer mode with 172 ticks left, line 0.
module lcd_mode_timing_stat_irq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] reg_addr, [15:8] write_data
	input  logic [1:0]  s_tuser,  // [1:0] item kind (op_t)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [7:0] read_data, [8] vblank pulse, [9] stat_irq,
	                              // [11:10] screen_mode, [19:12] line, [23:20] zero
);
	import lmts_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic      out_free, fire;
	seq_stat_t stat;
	step_res_t res;
	logic [7:0] rdata;

	logic       m_valid_q;
	logic [7:0] rdata_q;
	step_res_t  res_q;

	assign out_free = !m_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op   <= s_tuser;
			item_s1.addr <= s_tdata[7:0];
			item_s1.data <= s_tdata[15:8];
		end
	end

	lmts_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.stat   (stat),
		.res    (res)
	);

	lmts_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.stat   (stat),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rdata_q <= rdata;
			res_q   <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, res_q.line, res_q.mode, res_q.stat_irq, res_q.vblank_pulse,
		rdata_q};

	// vblank pulse only on entry to line 144 in vblank mode
	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.vblank_pulse |-> res_q.line == VBLANK_LINE &&
			res_q.mode == SM_VBLANK)
		else $error("vblank pulse away from line 144");

	// line counter stays within the frame
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.line < NUM_LINES)
		else $error("line counter out of range");

	// input stalls only when both stages hold an item and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_valid_q && !m_tready)
		else $error("input stalled without cause");

	// an item processed while output stalled must not have overwritten a result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |=> m_valid_q && $stable(m_tdata))
		else $error("pending result lost");

endmodule

### hdl/lmts_seq.sv
// Mode sequencer, line counter, line compare and status interrupt logic.
// Depends on lmts_pkg.
module lmts_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  lmts_pkg::item_t   item,
	output lmts_pkg::seq_stat_t stat,
	output lmts_pkg::step_res_t res
);
	import lmts_pkg::*;

	scr_mode_t  mode_q, mode_d;
	logic [8:0] dot_q, dot_d;
	logic [7:0] line_q, line_d;
	logic [7:0] cmp_q, cmp_d;
	logic [3:0] en_q, en_d;
	logic       coinc_q, coinc_d;
	logic [2:0] prev_q, prev_d;
	logic       enter, chk, vb, st;
	logic [2:0] cond;

	always_comb begin
		mode_d  = mode_q;
		dot_d   = dot_q;
		line_d  = line_q;
		cmp_d   = cmp_q;
		en_d    = en_q;
		coinc_d = coinc_q;
		prev_d  = prev_q;
		enter   = 1'b0;
		chk     = 1'b0;
		vb      = 1'b0;
		st      = 1'b0;
		cond    = 3'b000;
		if (fire) begin
			unique case (item.op)
				OP_TICK: begin
					if (dot_q > 9'd1) begin
						dot_d = dot_q - 9'd1;
					end else begin
						enter = 1'b1;
						unique case (mode_q)
							SM_TRANSFER: mode_d = SM_HBLANK;
							SM_HBLANK: begin
								line_d = line_q + 8'd1;
								if (line_d == VBLANK_LINE) begin
									mode_d = SM_VBLANK;
									vb     = 1'b1;
								end else begin
									mode_d = SM_SEARCH;
								end
							end
							SM_VBLANK: begin
								line_d = line_q + 8'd1;
								if (line_d >= NUM_LINES) begin
									line_d = 8'd0;
									mode_d = SM_SEARCH;
								end else begin
									mode_d = SM_VBLANK;
								end
							end
							default: mode_d = SM_TRANSFER;
						endcase
					end
				end
				OP_WRITE: begin
					if (item.addr == REG_STATUS) begin
						en_d = item.data[6:3];
						chk  = 1'b1;
					end else if (item.addr == REG_LYC) begin
						cmp_d = item.data;
						chk   = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (enter) begin
			dot_d = mode_dots(mode_d);
			chk   = 1'b1;
		end
		// status recheck on mode entry and on STAT/LYC writes
		if (chk) begin
			coinc_d = (line_d == cmp_d);
			cond    = {en_d[3] & coinc_d, en_d[1] & (mode_d == SM_VBLANK),
				en_d[0] & (mode_d == SM_HBLANK)};
			st      = |(cond & ~prev_q);
			prev_d  = cond;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= SM_TRANSFER;
			dot_q   <= DOTS_TRANSFER;
			line_q  <= 8'd0;
			cmp_q   <= 8'd0;
			en_q    <= 4'd0;
			coinc_q <= 1'b1;
			prev_q  <= 3'b000;
		end else begin
			mode_q  <= mode_d;
			dot_q   <= dot_d;
			line_q  <= line_d;
			cmp_q   <= cmp_d;
			en_q    <= en_d;
			coinc_q <= coinc_d;
			prev_q  <= prev_d;
		end
	end

	assign stat.mode        = mode_q;
	assign stat.coincidence = coinc_q;
	assign stat.enables     = en_q;
	assign stat.line        = line_q;
	assign stat.compare     = cmp_q;

	assign res.vblank_pulse = vb;
	assign res.stat_irq     = st;
	assign res.mode         = mode_d;
	assign res.line         = line_d;

endmodule

### hdl/lmts_regs.sv
// Plain LCD registers (control, scroll, palettes, window) and the register read mux.
// Depends on lmts_pkg; status and line values come from lmts_seq.
module lmts_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  lmts_pkg::item_t     item,
	input  lmts_pkg::seq_stat_t stat,
	output logic [7:0]          rdata
);
	import lmts_pkg::*;

	logic [7:0] lcdc_q, scy_q, scx_q, bgp_q, obp0_q, obp1_q, wy_q, wx_q;
	logic       wr;

	assign wr = fire && (item.op == OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcdc_q <= 8'd0;
			scy_q  <= 8'd0;
			scx_q  <= 8'd0;
			bgp_q  <= 8'd0;
			obp0_q <= 8'd0;
			obp1_q <= 8'd0;
			wy_q   <= 8'd0;
			wx_q   <= 8'd0;
		end else if (wr) begin
			unique case (item.addr)
				REG_CTRL:     lcdc_q <= item.data;
				REG_SCY:      scy_q  <= item.data;
				REG_SCX:      scx_q  <= item.data;
				REG_BGP:      bgp_q  <= item.data;
				REG_OBJ_PAL0: obp0_q <= item.data;
				REG_OBJ_PAL1: obp1_q <= item.data;
				REG_WY:       wy_q   <= item.data;
				REG_WX:       wx_q   <= item.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rdata = 8'd0;
		if (item.op == OP_READ) begin
			unique case (item.addr)
				REG_CTRL:     rdata = lcdc_q;
				REG_STATUS:   rdata = {1'b0, stat.enables, stat.coincidence, stat.mode};
				REG_SCY:      rdata = scy_q;
				REG_SCX:      rdata = scx_q;
				REG_LY:       rdata = stat.line;
				REG_LYC:      rdata = stat.compare;
				REG_BGP:      rdata = bgp_q;
				REG_OBJ_PAL0: rdata = obp0_q;
				REG_OBJ_PAL1: rdata = obp1_q;
				REG_WY:       rdata = wy_q;
				REG_WX:       rdata = wx_q;
				default:      rdata = 8'd0;
			endcase
		end
	end

endmodule

### tb/sv/tb_lcd_mode_timing_stat_irq.sv
// Self-checking testbench for lcd_mode_timing_stat_irq: a directed table, then random
// ticks and register traffic over several lines, checked against an in-bench model.
// Depends on lmts_pkg and the lcd_mode_timing_stat_irq RTL.
module tb_lcd_mode_timing_stat_irq;
	import lmts_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 4000;
	localparam int         HOLD_CYCLES = 500;
	localparam int         N_DIR       = 25;

	// m_tdata layout, msb first
	typedef struct packed {
		logic [3:0] pad;
		logic [7:0] line;
		logic [1:0] mode;
		logic       stat_irq;
		logic       vblank_pulse;
		logic [7:0] rd;
	} lcd_res_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] addr;
		logic [7:0] data;
		logic       typed;
		lcd_res_t   res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	lcd_mode_timing_stat_irq dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// timing model state
	scr_mode_t  cur_mode;
	logic [8:0] dots_left;
	logic [7:0] ly, lyc, lcdc, scy, scx, bgp, wy, wx;
	logic [7:0] obp [2];
	logic [3:0] stat_en;
	logic       coin;
	logic [2:0] prev_cond;

	lcd_res_t   pending_results [$];
	dir_row_t   dir_tab [N_DIR];
	int         errors;
	int         results_seen;
	int         idle_cycles;
	bit         calm;
	bit         hold_done;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// returns 1 when any enabled condition rose
	function automatic logic eval_stat();
		logic [2:0] cond;
		cond = 3'b000;
		coin = (ly == lyc);
		if (stat_en[0] && cur_mode == SM_HBLANK) cond[0] = 1'b1;
		if (stat_en[1] && cur_mode == SM_VBLANK) cond[1] = 1'b1;
		if (stat_en[3] && coin) cond[2] = 1'b1;
		eval_stat = |(cond & ~prev_cond);
		prev_cond = cond;
	endfunction

	function automatic logic enter(scr_mode_t m);
		cur_mode = m;
		case (m)
			SM_HBLANK: dots_left = DOTS_HBLANK;
			SM_VBLANK: dots_left = DOTS_VBLANK;
			SM_SEARCH: dots_left = DOTS_SEARCH;
			default:   dots_left = DOTS_TRANSFER;
		endcase
		return eval_stat();
	endfunction

	task automatic reset_model();
		ly = '0; lyc = '0; lcdc = '0; stat_en = '0; prev_cond = '0;
		scy = '0; scx = '0; bgp = '0; obp[0] = '0; obp[1] = '0; wy = '0; wx = '0;
		void'(enter(SM_TRANSFER));
	endtask

	function automatic lcd_res_t lcd_step(logic [1:0] op, logic [7:0] addr, logic [7:0] data);
		lcd_res_t r;
		r = '0;
		case (op)
			OP_TICK: begin
				if (dots_left > 9'd1) begin
					dots_left = dots_left - 9'd1;
				end else begin
					case (cur_mode)
						SM_TRANSFER: r.stat_irq = enter(SM_HBLANK);
						SM_HBLANK: begin
							ly = ly + 8'd1;
							if (ly == VBLANK_LINE) begin
								r.stat_irq = enter(SM_VBLANK);
								r.vblank_pulse = 1'b1;
							end else begin
								r.stat_irq = enter(SM_SEARCH);
							end
						end
						SM_VBLANK: begin
							ly = ly + 8'd1;
							if (ly >= NUM_LINES) begin
								ly = '0;
								r.stat_irq = enter(SM_SEARCH);
							end else begin
								r.stat_irq = enter(SM_VBLANK);
							end
						end
						default: r.stat_irq = enter(SM_TRANSFER);
					endcase
				end
			end
			OP_READ: begin
				case (addr)
					REG_CTRL:     r.rd = lcdc;
					REG_STATUS:   r.rd = {1'b0, stat_en, coin, cur_mode};
					REG_SCY:      r.rd = scy;
					REG_SCX:      r.rd = scx;
					REG_LY:       r.rd = ly;
					REG_LYC:      r.rd = lyc;
					REG_BGP:      r.rd = bgp;
					REG_OBJ_PAL0: r.rd = obp[0];
					REG_OBJ_PAL1: r.rd = obp[1];
					REG_WY:       r.rd = wy;
					REG_WX:       r.rd = wx;
					default:      r.rd = '0;
				endcase
			end
			OP_WRITE: begin
				case (addr)
					REG_CTRL: lcdc = data;
					REG_STATUS: begin
						stat_en = data[6:3];
						r.stat_irq = eval_stat();
					end
					REG_SCY:  scy = data;
					REG_SCX:  scx = data;
					REG_LYC: begin
						lyc = data;
						r.stat_irq = eval_stat();
					end
					REG_BGP:      bgp = data;
					REG_OBJ_PAL0: obp[0] = data;
					REG_OBJ_PAL1: obp[1] = data;
					REG_WY:       wy = data;
					REG_WX:       wx = data;
					default: ;
				endcase
			end
			default: ;
		endcase
		r.mode = cur_mode;
		r.line = ly;
		return r;
	endfunction

	function automatic lcd_res_t res_of(logic [7:0] rd, logic st, logic [7:0] line);
		lcd_res_t r;
		r = '0;
		r.rd = rd;
		r.stat_irq = st;
		r.mode = SM_TRANSFER;
		r.line = line;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 1;
		if (r < 95) return $urandom_range(2, 4);
		return $urandom_range(5, 40);
	endfunction

	// called just after a falling edge; returns just after a falling edge, once the item has been accepted
	task automatic offer(input logic [1:0] op, input logic [7:0] addr, input logic [7:0] data,
			input logic typed, input lcd_res_t typed_res);
		int n;
		lcd_res_t r;
		if (!calm && $urandom_range(0, 99) < 25) begin
			n = idle_len();
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {data, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = lcd_step(op, addr, data);
		pending_results.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	initial begin
		int i;
		int n_items;
		int r;
		logic [1:0] op;
		logic [7:0] addr;
		logic [7:0] data;

		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;
		errors   = 0;
		calm     = 1'b0;
		reset_model();

		// after reset: transfer mode, line 0, coincident with compare 0
		dir_tab = '{
			'{OP_READ,   REG_STATUS,   8'h00, 1'b1, res_of(8'h07, 1'b0, 8'd0)},
			'{OP_READ,   REG_LY,       8'hFF, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_READ,   8'h46,        8'h00, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_READ,   8'hFF,        8'hFF, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_READ,   8'h00,        8'h00, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_WRITE,  REG_CTRL,     8'hFF, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_READ,   REG_CTRL,     8'h00, 1'b1, res_of(8'hFF, 1'b0, 8'd0)},
			'{OP_WRITE,  REG_LY,       8'hAA, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_READ,   REG_LY,       8'h00, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_WRITE,  8'h46,        8'h55, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_READ,   8'h46,        8'h00, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_UNUSED, REG_CTRL,     8'hFF, 1'b1, res_of(8'h00, 1'b0, 8'd0)},
			'{OP_WRITE,  REG_STATUS,   8'hFF, 1'b1, res_of(8'h00, 1'b1, 8'd0)},
			'{OP_READ,   REG_STATUS,   8'h00, 1'b1, res_of(8'h7F, 1'b0, 8'd0)},
			'{OP_WRITE,  REG_LYC,      8'hFF, 1'b0, '0},
			'{OP_READ,   REG_LYC,      8'h00, 1'b0, '0},
			'{OP_WRITE,  REG_LYC,      8'h00, 1'b0, '0},
			'{OP_WRITE,  REG_SCY,      8'h00, 1'b0, '0},
			'{OP_WRITE,  REG_SCX,      8'hFF, 1'b0, '0},
			'{OP_WRITE,  REG_BGP,      8'hA5, 1'b0, '0},
			'{OP_WRITE,  REG_OBJ_PAL0, 8'h5A, 1'b0, '0},
			'{OP_WRITE,  REG_OBJ_PAL1, 8'hFF, 1'b0, '0},
			'{OP_WRITE,  REG_WY,       8'h01, 1'b0, '0},
			'{OP_WRITE,  REG_WX,       8'h80, 1'b0, '0},
			'{OP_WRITE,  REG_STATUS,   8'h00, 1'b0, '0}
		};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < N_DIR; i++)
			offer(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].data, dir_tab[i].typed,
				dir_tab[i].res);

		// drain before the random traffic
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);

		// mostly ticks so the sequencer steps through several lines
		n_items = 0;
		while (n_items < 1700) begin
			if (n_items % 200 == 0) calm = ($urandom_range(0, 3) == 0);
			r    = $urandom_range(0, 99);
			addr = 8'($urandom_range(0, 255));
			data = 8'($urandom_range(0, 255));
			if (r < 88) begin
				op = OP_TICK;
			end else if (r < 98) begin
				op = (r < 93) ? OP_READ : OP_WRITE;
				if ($urandom_range(0, 9) < 7) addr = 8'($urandom_range(REG_CTRL, REG_WX));
				if (op == OP_WRITE && addr == REG_LYC && $urandom_range(0, 3) != 0)
					data = 8'($urandom_range(0, NUM_LINES - 1));
			end else begin
				op = OP_UNUSED;
			end
			offer(op, addr, data, 1'b0, '0);
			n_items++;
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("lcd_mode_timing_stat_irq test passed");
		else
			$display("lcd_mode_timing_stat_irq test failed");
		$finish;
	end

	// result side backpressure, with one long hold-off to fill the block
	initial begin
		int stall_left;
		m_tready  = 1'b0;
		hold_done = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 300) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= arst_n;
				if (!calm && $urandom_range(0, 99) < 15) stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin : check_results
		lcd_res_t want;
		lcd_res_t got;
		if (m_tvalid && m_tready) begin
			results_seen++;
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.rd !== want.rd) begin
					$error("read_data: expected %h, got %h", want.rd, got.rd);
					errors++;
				end
				if (got.vblank_pulse !== want.vblank_pulse) begin
					$error("vblank_pulse: expected %b, got %b", want.vblank_pulse,
						got.vblank_pulse);
					errors++;
				end
				if (got.stat_irq !== want.stat_irq) begin
					$error("stat_irq: expected %b, got %b", want.stat_irq, got.stat_irq);
					errors++;
				end
				if (got.mode !== want.mode) begin
					$error("screen_mode: expected %0d, got %0d", want.mode, got.mode);
					errors++;
				end
				if (got.line !== want.line) begin
					$error("line: expected %0d, got %0d", want.line, got.line);
					errors++;
				end
				if (got.pad !== want.pad) begin
					$error("pad: expected %h, got %h", want.pad, got.pad);
					errors++;
				end
			end
		end
	end

	initial begin
		results_seen = 0;
		idle_cycles  = 0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("lcd_mode_timing_stat_irq test failed");
			$finish;
		end
	end

endmodule

### sim.f
hdl/lmts_pkg.sv
hdl/lmts_seq.sv
hdl/lmts_regs.sv
hdl/lcd_mode_timing_stat_irq.sv
tb/sv/tb_lcd_mode_timing_stat_irq.sv
